### rtl/core/fifo_queue_with_extract_min_assert.svh
// assertion macros shared by the checker of the extract-min queue
`ifndef FIFO_QUEUE_WITH_EXTRACT_MIN_ASSERT_SVH
`define FIFO_QUEUE_WITH_EXTRACT_MIN_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define FQM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define FQM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fqm_pkg.sv
// shared types and constants of the extract-min queue
package fqm_pkg;

  localparam int VALUE_W     = 32;
  localparam int COUNT_OUT_W = 7;

  localparam logic signed [VALUE_W-1:0] WMIN_INIT = 32'sh7fffffff;

  typedef enum logic [1:0] {
    MODE_APPEND     = 2'd0,
    MODE_POP_FRONT  = 2'd1,
    MODE_READ_FRONT = 2'd2,
    MODE_POP_MIN    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    C_HOLD,
    C_APPEND,
    C_POP,
    C_START,
    C_SCAN,
    C_EXTRACT
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } ctrl_state_t;

  // minimum-search wave handed from a cell to its front neighbor
  typedef struct packed {
    logic                      tok;
    logic signed [VALUE_W-1:0] wmin;
  } wave_t;

  typedef struct packed {
    cell_op_t op;
    logic     any_best;
  } cell_cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
    logic [COUNT_OUT_W-1:0]    count;
  } res_t;

endpackage

### rtl/core/fqm_cell.sv
// one queue cell: holds an entry and takes part in the rear-to-front minimum wave
module fqm_cell #(
  parameter int IW    = 6,
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fqm_pkg::cell_cmd_t                cmd,
  input  logic [IW-1:0]                     tgt,
  input  logic signed [fqm_pkg::VALUE_W-1:0] din,
  input  logic signed [fqm_pkg::VALUE_W-1:0] right_val,
  input  fqm_pkg::wave_t                    right_wave,
  output logic signed [fqm_pkg::VALUE_W-1:0] val,
  output fqm_pkg::wave_t                    wave_out,
  output logic                              best
);
  import fqm_pkg::*;

  logic                      tok;
  logic signed [VALUE_W-1:0] wmin;
  logic                      visited;
  logic                      drop;
  logic                      drop_next;
  logic                      hit;

  assign hit  = (tgt == IW'(INDEX));
  // ties go to the cell nearer the front, which the wave reaches later
  assign best = tok && (val <= wmin);

  assign wave_out.tok  = tok;
  assign wave_out.wmin = best ? val : wmin;

  // drop marks cells at or behind the current best position
  always_comb begin
    if (tok) begin
      drop_next = best;
    end else if (visited) begin
      drop_next = drop | cmd.any_best;
    end else begin
      drop_next = drop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok     <= 1'b0;
      visited <= 1'b0;
      drop    <= 1'b0;
    end else begin
      case (cmd.op)
        C_START: begin
          tok     <= hit;
          visited <= 1'b0;
          drop    <= 1'b0;
        end
        C_SCAN, C_EXTRACT: begin
          tok     <= right_wave.tok;
          visited <= visited | tok;
          drop    <= drop_next;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      C_APPEND: begin
        if (hit) val <= din;
      end
      C_POP: val <= right_val;
      C_START: wmin <= WMIN_INIT;
      C_SCAN: wmin <= right_wave.wmin;
      C_EXTRACT: begin
        if (drop_next) val <= right_val;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/fqm_ctrl.sv
// operation sequencer and entry counter of the extract-min queue
module fqm_ctrl #(
  parameter int CAPACITY = 64,
  parameter int IW       = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_valid,
  output logic                               s_ready,
  input  logic                               room,
  input  fqm_pkg::mode_t                     mode,
  input  logic signed [fqm_pkg::VALUE_W-1:0] head_val,
  input  fqm_pkg::wave_t                     head_wave,
  output fqm_pkg::cell_op_t                  op,
  output logic [IW-1:0]                      tgt,
  output logic                               push,
  output fqm_pkg::res_t                      res
);
  import fqm_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  ctrl_state_t   state;
  ctrl_state_t   state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] cnt_m1;
  logic          empty;
  logic          full;

  assign cnt_m1 = count - CW'(1);
  assign empty  = (count == '0);
  assign full   = (count == CW'(CAPACITY));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    op         = C_HOLD;
    tgt        = count[IW-1:0];
    push       = 1'b0;
    s_ready    = 1'b0;
    res.value  = '0;
    res.status = STAT_OK;
    case (state)
      S_IDLE: begin
        s_ready = room;
        if (s_valid && room) begin
          case (mode)
            MODE_APPEND: begin
              push = 1'b1;
              if (full) begin
                res.status = STAT_FULL;
              end else begin
                op         = C_APPEND;
                count_next = count + CW'(1);
              end
            end
            MODE_POP_FRONT: begin
              push = 1'b1;
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                op         = C_POP;
                res.value  = head_val;
                count_next = cnt_m1;
              end
            end
            MODE_READ_FRONT: begin
              push = 1'b1;
              if (empty) begin
                res.status = STAT_EMPTY;
              end else begin
                res.value = head_val;
              end
            end
            MODE_POP_MIN: begin
              if (empty) begin
                push       = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                op         = C_START;
                tgt        = cnt_m1[IW-1:0];
                state_next = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        op = C_SCAN;
        if (head_wave.tok) begin
          op         = C_EXTRACT;
          push       = 1'b1;
          res.value  = head_wave.wmin;
          count_next = cnt_m1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    res.count = COUNT_OUT_W'(count_next);
  end

endmodule

### rtl/core/fifo_queue_with_extract_min.sv
// top level of the ordered queue with remove-minimum
// usage:
//   each input item on the s_ group is one operation: s_tuser selects it (append,
//   remove front, read front, remove minimum) and s_tdata carries the value to append.
//   every item gives exactly one result item on the m_ group: the returned value and
//   entry count in m_tdata and the status (ok, empty, full) in m_tuser.
// operations:
//   append, remove front, read front and any empty or full case finish in the accept
//   cycle; the result is registered into the output slots and a new item can follow
//   every cycle while the spare result slot is empty. remove minimum sends a search
//   wave from the rearmost entry toward the front, one cell per cycle; the result is
//   pushed when the wave reaches the front cell and the block takes no item meanwhile.
// reset:
//   the queue is emptied (entry count zero) and both result slots are cleared; the
//   cell contents are not reset and are only read once written.
// stalls:
//   two result slots sit at the output, so one item is still accepted while a result
//   waits; with both slots full s_tready drops until m_tready takes one.
module fifo_queue_with_extract_min #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] result_value, [38:32] entry_count, [39] zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import fqm_pkg::*;

  localparam int IW = $clog2(CAPACITY);

  // cell row, index 0 is the front; the extra slot feeds the rearmost cell
  logic signed [VALUE_W-1:0] val_w [CAPACITY+1];
  wave_t                     wave_w [CAPACITY+1];
  logic [CAPACITY-1:0]       best_w;

  cell_op_t      op;
  cell_cmd_t     cmd;
  logic [IW-1:0] tgt;
  logic          push;
  res_t          res;

  // output slots: head drives the port, spare catches a result while head waits
  res_t head;
  res_t spare;
  logic head_valid;
  logic spare_valid;
  logic pop;

  assign val_w[CAPACITY]  = '0;
  assign wave_w[CAPACITY] = '0;

  // a single cell holds the token, so this is the best flag of that cell
  assign cmd.op       = op;
  assign cmd.any_best = |best_w;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      fqm_cell #(
        .IW    (IW),
        .INDEX (i)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .tgt        (tgt),
        .din        (s_tdata),
        .right_val  (val_w[i+1]),
        .right_wave (wave_w[i+1]),
        .val        (val_w[i]),
        .wave_out   (wave_w[i]),
        .best       (best_w[i])
      );
    end
  endgenerate

  fqm_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_tvalid),
    .s_ready   (s_tready),
    .room      (!spare_valid),
    .mode      (mode_t'(s_tuser)),
    .head_val  (val_w[0]),
    .head_wave (wave_w[0]),
    .op        (op),
    .tgt       (tgt),
    .push      (push),
    .res       (res)
  );

  assign pop = head_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b0;
      spare_valid <= 1'b0;
    end else begin
      if (pop && !push) begin
        if (spare_valid) begin
          spare_valid <= 1'b0;
        end else begin
          head_valid <= 1'b0;
        end
      end else if (push && !pop) begin
        if (head_valid) begin
          spare_valid <= 1'b1;
        end else begin
          head_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      // head leaves: refill from spare first to keep order
      if (spare_valid) begin
        head <= spare;
        if (push) spare <= res;
      end else if (push) begin
        head <= res;
      end
    end else if (push) begin
      if (head_valid) begin
        spare <= res;
      end else begin
        head <= res;
      end
    end
  end

  assign m_tvalid = head_valid;
  assign m_tdata  = {1'b0, head.count, head.value};
  assign m_tuser  = head.status;

endmodule

### rtl/core/fqm_checker.sv
// port checker of the extract-min queue and its bind to the top level
`include "fifo_queue_with_extract_min_assert.svh"

module fqm_checker #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import fqm_pkg::*;

  `FQM_ASSERT_NEXT(a_out_valid_held, m_tvalid && !m_tready, m_tvalid,
                   "result item dropped while stalled")
  `FQM_ASSERT_NEXT(a_out_data_held, m_tvalid && !m_tready,
                   $stable(m_tdata) && $stable(m_tuser),
                   "stalled result item changed")
  `FQM_ASSERT_NOW(a_empty_zero, m_tvalid && (m_tuser == STAT_EMPTY), m_tdata == 40'd0,
                  "empty status with nonzero value or count")
  `FQM_ASSERT_NOW(a_full_count, m_tvalid && (m_tuser == STAT_FULL),
                  (m_tdata[38:32] == COUNT_OUT_W'(CAPACITY)) && (m_tdata[31:0] == 32'd0),
                  "full status without full count")

endmodule

bind fifo_queue_with_extract_min fqm_checker #(
  .CAPACITY (CAPACITY)
) u_fqm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
